// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the RTL of the trie prefix matcher.
// Stand-alone header; a module that asserts includes it by file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");

// Concurrent assertion on the usual clk_i and rst_ni of a module.
`define ASSERT_STD(lbl, prop) \
  `ASSERT_CLK(lbl, clk_i, rst_ni, prop)

`endif

// ----- hw/rtl/tpm_pkg.sv -----
// Types, constants and helpers of the trie prefix matcher.
// Used by tpm_ram users and by the top level; depends on nothing.
`default_nettype none

package tpm_pkg;

  localparam int NODES           = 256;
  localparam int ALPHABET        = 26;
  localparam int TEXT_DEPTH      = 256;
  localparam int MAX_PATTERN_LEN = 16;

  // Fixed field widths of the stream items
  localparam int CMD_W       = 2;
  localparam int LETTER_W    = 5;
  localparam int POS_W       = 8;
  localparam int STATUS_W    = 3;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 8;

  localparam int NODE_W      = $clog2(NODES);
  localparam int NODE_CNT_W  = $clog2(NODES + 1);
  localparam int CHILD_DEPTH = NODES * ALPHABET;
  localparam int CHILD_AW    = $clog2(CHILD_DEPTH);
  localparam int CHILD_W     = NODE_W + 1;          // {word end of child, child index}
  localparam int TEXT_AW     = $clog2(TEXT_DEPTH);
  localparam int TEXT_LEN_W  = $clog2(TEXT_DEPTH + 1);
  localparam int LEN_W       = $clog2(MAX_PATTERN_LEN + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_PAT_LETTER  = 2'd0,
    CMD_PAT_END     = 2'd1,
    CMD_TEXT_LETTER = 2'd2,
    CMD_SEARCH      = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 3'd0,
    STAT_TRIE_FULL = 3'd1,
    STAT_TEXT_FULL = 3'd2,
    STAT_TOO_LONG  = 3'd3,
    STAT_BAD_POS   = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PLET,
    ST_SFETCH,
    ST_WALK,
    ST_LAST
  } state_e;

  // Child table entry address of a node and a letter
  function automatic logic [CHILD_AW-1:0] slot_addr(logic [NODE_W-1:0]   node,
                                                    logic [LETTER_W-1:0] letter);
    return CHILD_AW'(node) * CHILD_AW'(ALPHABET) + CHILD_AW'(letter);
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/tpm_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// Read data holds until the next read. No dependencies.
`default_nettype none

module tpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- hw/rtl/trie_multi_pattern_prefix_matcher.sv -----
// A search reads k child table entries (k <= 16).
// Throughput: one item at a time; a search walks one node a cycle, stalling only when
// it hits a further word end while the output register is held.
// Reset: a clearing pass writes all 6656 child table entries, one a cycle, while
// s_axis_tready stays low. The text buffer is not cleared.
`default_nettype none
`include "assert_macros.svh"

module trie_multi_pattern_prefix_matcher (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  input  wire logic [tpm_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // letter[4:0], position[12:5]
  input  wire logic [tpm_pkg::CMD_W-1:0]           s_axis_tuser,  // command[1:0]
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  output logic      [tpm_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,  // found[0], match_length[5:1]
  output logic      [tpm_pkg::STATUS_W-1:0]        m_axis_tuser,  // status[2:0]
  output logic                                     m_axis_tlast
);

  localparam int NW = tpm_pkg::NODE_W;
  localparam int AW = tpm_pkg::CHILD_AW;
  localparam int LW = tpm_pkg::LEN_W;
  localparam int TW = tpm_pkg::TEXT_LEN_W;

  tpm_pkg::state_e  state_q, state_d;
  logic             clr_q, clr_d;
  logic [AW-1:0]    clr_addr_q, clr_addr_d;
  logic [tpm_pkg::NODE_CNT_W-1:0] node_count_q, node_count_d;
  logic [NW-1:0]    cursor_q, cursor_d;
  logic [AW-1:0]    ins_slot_q, ins_slot_d;
  logic [LW-1:0]    ins_depth_q, ins_depth_d;
  logic             ins_failed_q, ins_failed_d;
  logic [TW-1:0]    text_len_q, text_len_d;
  logic [AW-1:0]    slot_q, slot_d;
  logic [TW-1:0]    pos_q, pos_d;
  logic [LW-1:0]    steps_q, steps_d;
  tpm_pkg::status_e res_status_q, res_status_d;
  logic             pend_found_q, pend_found_d;
  logic [LW-1:0]    pend_len_q, pend_len_d;

  logic             out_valid_q, out_valid_d;
  tpm_pkg::status_e out_status_q, out_status_d;
  logic             out_found_q, out_found_d;
  logic [LW-1:0]    out_len_q, out_len_d;
  logic             out_last_q, out_last_d;

  logic                             child_we, child_re;
  logic [AW-1:0]                    child_waddr, child_raddr;
  logic [tpm_pkg::CHILD_W-1:0]      child_wdata, child_rdata;
  logic                             text_we, text_re;
  logic [tpm_pkg::TEXT_AW-1:0]      text_waddr, text_raddr;
  logic [tpm_pkg::LETTER_W-1:0]     text_wdata, text_rdata;

  logic                             in_xfer, out_free, stall;
  logic [tpm_pkg::LETTER_W-1:0]     letter_c;
  logic [tpm_pkg::POS_W-1:0]        position;
  tpm_pkg::cmd_e                    command;
  logic [NW-1:0]                    next_node;
  logic                             next_wend;
  logic [LW-1:0]                    steps_inc;
  logic [TW-1:0]                    pos_inc;

  assign command  = tpm_pkg::cmd_e'(s_axis_tuser);
  assign position = s_axis_tdata[tpm_pkg::LETTER_W +: tpm_pkg::POS_W];
  assign letter_c = (int'(s_axis_tdata[tpm_pkg::LETTER_W-1:0]) >= tpm_pkg::ALPHABET) ?
                    tpm_pkg::LETTER_W'(tpm_pkg::ALPHABET - 1) :
                    s_axis_tdata[tpm_pkg::LETTER_W-1:0];

  assign s_axis_tready = (state_q == tpm_pkg::ST_IDLE) && !clr_q;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  assign next_node = child_rdata[NW-1:0];
  assign next_wend = child_rdata[NW];
  assign steps_inc = steps_q + LW'(1);
  assign pos_inc   = pos_q + TW'(1);
  // A second hit while the previous one still waits for the output register
  assign stall     = (state_q == tpm_pkg::ST_WALK) && (next_node != '0) && next_wend &&
                     pend_found_q && !out_free;

  tpm_ram #(
    .WIDTH (tpm_pkg::CHILD_W),
    .DEPTH (tpm_pkg::CHILD_DEPTH)
  ) u_child_ram (
    .clk_i   (clk_i),
    .we_i    (child_we),
    .waddr_i (child_waddr),
    .wdata_i (child_wdata),
    .re_i    (child_re),
    .raddr_i (child_raddr),
    .rdata_o (child_rdata)
  );

  tpm_ram #(
    .WIDTH (tpm_pkg::LETTER_W),
    .DEPTH (tpm_pkg::TEXT_DEPTH)
  ) u_text_ram (
    .clk_i   (clk_i),
    .we_i    (text_we),
    .waddr_i (text_waddr),
    .wdata_i (text_wdata),
    .re_i    (text_re),
    .raddr_i (text_raddr),
    .rdata_o (text_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= tpm_pkg::ST_IDLE;
      clr_q        <= 1'b1;
      clr_addr_q   <= '0;
      node_count_q <= tpm_pkg::NODE_CNT_W'(1);
      cursor_q     <= '0;
      ins_depth_q  <= '0;
      ins_failed_q <= 1'b0;
      text_len_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      clr_q        <= clr_d;
      clr_addr_q   <= clr_addr_d;
      node_count_q <= node_count_d;
      cursor_q     <= cursor_d;
      ins_depth_q  <= ins_depth_d;
      ins_failed_q <= ins_failed_d;
      text_len_q   <= text_len_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ins_slot_q   <= ins_slot_d;
    slot_q       <= slot_d;
    pos_q        <= pos_d;
    steps_q      <= steps_d;
    res_status_q <= res_status_d;
    pend_found_q <= pend_found_d;
    pend_len_q   <= pend_len_d;
    out_status_q <= out_status_d;
    out_found_q  <= out_found_d;
    out_len_q    <= out_len_d;
    out_last_q   <= out_last_d;
  end

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    clr_addr_d   = clr_addr_q;
    node_count_d = node_count_q;
    cursor_d     = cursor_q;
    ins_slot_d   = ins_slot_q;
    ins_depth_d  = ins_depth_q;
    ins_failed_d = ins_failed_q;
    text_len_d   = text_len_q;
    slot_d       = slot_q;
    pos_d        = pos_q;
    steps_d      = steps_q;
    res_status_d = res_status_q;
    pend_found_d = pend_found_q;
    pend_len_d   = pend_len_q;

    out_valid_d  = out_valid_q && !m_axis_tready;
    out_status_d = out_status_q;
    out_found_d  = out_found_q;
    out_len_d    = out_len_q;
    out_last_d   = out_last_q;

    child_we    = 1'b0;
    child_waddr = '0;
    child_wdata = '0;
    child_re    = 1'b0;
    child_raddr = '0;
    text_we     = 1'b0;
    text_waddr  = '0;
    text_wdata  = '0;
    text_re     = 1'b0;
    text_raddr  = '0;

    // Sweep the child table to all zero after reset
    if (clr_q) begin
      child_we    = 1'b1;
      child_waddr = clr_addr_q;
      if (clr_addr_q == AW'(tpm_pkg::CHILD_DEPTH - 1)) begin
        clr_d = 1'b0;
      end else begin
        clr_addr_d = clr_addr_q + AW'(1);
      end
    end

    case (state_q)
      tpm_pkg::ST_IDLE: begin
        if (in_xfer) begin
          res_status_d = tpm_pkg::STAT_OK;
          pend_found_d = 1'b0;
          pend_len_d   = '0;
          state_d      = tpm_pkg::ST_LAST;
          case (command)
            tpm_pkg::CMD_PAT_LETTER: begin
              if (ins_failed_q) begin
                // letters of a failed pattern are ignored
              end else if (int'(ins_depth_q) >= tpm_pkg::MAX_PATTERN_LEN) begin
                ins_failed_d = 1'b1;
                res_status_d = tpm_pkg::STAT_TOO_LONG;
              end else begin
                child_re    = 1'b1;
                child_raddr = tpm_pkg::slot_addr(cursor_q, letter_c);
                slot_d      = tpm_pkg::slot_addr(cursor_q, letter_c);
                state_d     = tpm_pkg::ST_PLET;
              end
            end
            tpm_pkg::CMD_PAT_END: begin
              // mark the word end in the entry that points at the cursor node
              if (!ins_failed_q && (cursor_q != '0)) begin
                child_we    = 1'b1;
                child_waddr = ins_slot_q;
                child_wdata = {1'b1, cursor_q};
              end
              cursor_d     = '0;
              ins_depth_d  = '0;
              ins_failed_d = 1'b0;
            end
            tpm_pkg::CMD_TEXT_LETTER: begin
              if (int'(text_len_q) >= tpm_pkg::TEXT_DEPTH) begin
                res_status_d = tpm_pkg::STAT_TEXT_FULL;
              end else begin
                text_we    = 1'b1;
                text_waddr = text_len_q[tpm_pkg::TEXT_AW-1:0];
                text_wdata = letter_c;
                text_len_d = text_len_q + TW'(1);
              end
            end
            tpm_pkg::CMD_SEARCH: begin
              if (TW'(position) >= text_len_q) begin
                res_status_d = tpm_pkg::STAT_BAD_POS;
              end else begin
                text_re    = 1'b1;
                text_raddr = tpm_pkg::TEXT_AW'(position);
                pos_d      = TW'(position);
                steps_d    = '0;
                state_d    = tpm_pkg::ST_SFETCH;
              end
            end
            default: begin
              state_d = tpm_pkg::ST_LAST;
            end
          endcase
        end
      end

      tpm_pkg::ST_PLET: begin
        state_d = tpm_pkg::ST_LAST;
        if (next_node == '0) begin
          if (int'(node_count_q) >= tpm_pkg::NODES) begin
            ins_failed_d = 1'b1;
            res_status_d = tpm_pkg::STAT_TRIE_FULL;
          end else begin
            child_we     = 1'b1;
            child_waddr  = slot_q;
            child_wdata  = {1'b0, node_count_q[NW-1:0]};
            cursor_d     = node_count_q[NW-1:0];
            node_count_d = node_count_q + tpm_pkg::NODE_CNT_W'(1);
            ins_slot_d   = slot_q;
            ins_depth_d  = ins_depth_q + LW'(1);
          end
        end else begin
          cursor_d    = next_node;
          ins_slot_d  = slot_q;
          ins_depth_d = ins_depth_q + LW'(1);
        end
      end

      tpm_pkg::ST_SFETCH: begin
        // first letter in; prefetch the one after it
        child_re    = 1'b1;
        child_raddr = tpm_pkg::slot_addr(NW'(0), text_rdata);
        text_re     = 1'b1;
        text_raddr  = pos_inc[tpm_pkg::TEXT_AW-1:0];
        state_d     = tpm_pkg::ST_WALK;
      end

      tpm_pkg::ST_WALK: begin
        if (!stall) begin
          if (next_node == '0) begin
            state_d = tpm_pkg::ST_LAST;
          end else begin
            if (next_wend) begin
              if (pend_found_q) begin
                out_valid_d  = 1'b1;
                out_status_d = tpm_pkg::STAT_OK;
                out_found_d  = 1'b1;
                out_len_d    = pend_len_q;
                out_last_d   = 1'b0;
              end
              pend_found_d = 1'b1;
              pend_len_d   = steps_inc;
            end
            if ((pos_inc < text_len_q) && (int'(steps_inc) < tpm_pkg::MAX_PATTERN_LEN)) begin
              child_re    = 1'b1;
              child_raddr = tpm_pkg::slot_addr(next_node, text_rdata);
              text_re     = 1'b1;
              text_raddr  = tpm_pkg::TEXT_AW'(pos_q + TW'(2));
              pos_d       = pos_inc;
              steps_d     = steps_inc;
            end else begin
              state_d = tpm_pkg::ST_LAST;
            end
          end
        end
      end

      tpm_pkg::ST_LAST: begin
        // the held result goes out flagged last
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_found_d  = pend_found_q;
          out_len_d    = pend_len_q;
          out_last_d   = 1'b1;
          state_d      = tpm_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = tpm_pkg::ST_IDLE;
      end
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = tpm_pkg::OUT_TDATA_W'({out_len_q, out_found_q});
  assign m_axis_tlast  = out_last_q;

  `ASSERT_STD(a_no_accept_while_clearing, clr_q |-> !s_axis_tready)
  `ASSERT_STD(a_walk_within_reach,
              (state_q == tpm_pkg::ST_WALK) |-> (int'(steps_q) < tpm_pkg::MAX_PATTERN_LEN))
  `ASSERT_STD(a_cursor_allocated, cursor_q < node_count_q[NW-1:0] || node_count_q[NW])
  `ASSERT_STD(a_node_count_bound, int'(node_count_q) <= tpm_pkg::NODES)
  `ASSERT_STD(a_found_has_length, (out_valid_q && out_found_q) |-> (out_len_q != '0))
  `ASSERT_STD(a_accept_leaves_idle, in_xfer |=> (state_q != tpm_pkg::ST_IDLE))

endmodule

`default_nettype wire
